### hdl/benc_pkg.sv
package benc_pkg;

    localparam logic [7:0] C_PAD_CHAR = 8'h3D;
    localparam int unsigned C_QUEUE_DEPTH = 2;
    localparam logic [0:0] C_REG_ALPHABET_MODE = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_enc_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       message_end;
    } t_enc_out;

    // One input byte worth of output: up to three alphabet characters, then pads.
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      n_real;
        logic [3:0]      n_total;
        logic            fin;
    } t_job;

    typedef struct packed {
        logic mode;
        logic clear;
    } t_ctrl;

    function automatic logic [7:0] map_symbol(input logic mode, input logic [5:0] v);
        logic [7:0] c;
        c = 8'h00;
        if (mode) begin
            if (v[4:0] < 5'd26) c = 8'h41 + {3'b000, v[4:0]};
            else                c = 8'h32 + {3'b000, v[4:0]} - 8'd26;
        end else begin
            if (v < 6'd26)      c = 8'h41 + {2'b00, v};
            else if (v < 6'd52) c = 8'h61 + {2'b00, v} - 8'd26;
            else if (v < 6'd62) c = 8'h30 + {2'b00, v} - 8'd52;
            else if (v == 6'd62) c = 8'h2B;
            else                c = 8'h2F;
        end
        return c;
    endfunction

endpackage

### hdl/benc_front.sv
module benc_front import benc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ctrl   i_ctrl,
    input  logic    i_valid,
    input  t_enc_in i_data,
    input  logic    i_full,
    output logic    o_push,
    output t_job    o_job
);

    logic [3:0] r_leftover_bits, n_leftover_bits;
    logic [2:0] r_leftover_count, n_leftover_count;
    logic [2:0] r_group_count, n_group_count;

    logic [11:0] acc;
    logic [11:0] tail;
    logic [11:0] sh0, sh1, sh2;
    logic [3:0]  nbits, rem1, rem2, rem;
    logic [3:0]  sym;
    logic [5:0]  mask;
    logic        two, fill, fin;
    logic [1:0]  cnt;
    logic [2:0]  grp;
    logic [2:0]  pads;
    logic [3:0]  total;

    assign o_push = i_valid && !i_full;
    assign fin    = i_data.final_byte;

    always_comb begin
        sym   = i_ctrl.mode ? 4'd5 : 4'd6;
        mask  = i_ctrl.mode ? 6'h1F : 6'h3F;
        nbits = {1'b0, r_leftover_count} + 4'd8;
        acc   = {r_leftover_bits, i_data.data_byte};
        rem1  = nbits - sym;
        two   = rem1 >= sym;
        rem2  = rem1 - sym;
        rem   = two ? rem2 : rem1;
        sh0   = acc >> rem1;
        sh1   = acc >> rem2;
        tail  = acc & ((12'd1 << rem) - 12'd1);
        sh2   = tail << (sym - rem);
        fill  = fin && (rem != 4'd0);
        cnt   = 2'd1 + {1'b0, two} + {1'b0, fill};
        grp   = r_group_count + {1'b0, cnt};
        if (!fin)              pads = 3'd0;
        else if (i_ctrl.mode)  pads = 3'd0 - grp;
        else                   pads = {1'b0, 2'd0 - grp[1:0]};
        total = {2'b00, cnt} + {1'b0, pads};
        if (total > 4'd8) total = 4'd8;

        o_job.chars[0] = map_symbol(i_ctrl.mode, sh0[5:0] & mask);
        o_job.chars[1] = map_symbol(i_ctrl.mode, sh1[5:0] & mask);
        o_job.chars[2] = map_symbol(i_ctrl.mode, sh2[5:0] & mask);
        // A fill character lands in slot 1 when only one data symbol came out.
        if (!two) o_job.chars[1] = o_job.chars[2];
        o_job.n_real  = cnt;
        o_job.n_total = total;
        o_job.fin     = fin;
    end

    always_comb begin
        n_leftover_bits  = r_leftover_bits;
        n_leftover_count = r_leftover_count;
        n_group_count    = r_group_count;
        if (i_ctrl.clear) begin
            n_leftover_bits  = 4'd0;
            n_leftover_count = 3'd0;
            n_group_count    = 3'd0;
        end else if (o_push) begin
            if (fin) begin
                n_leftover_bits  = 4'd0;
                n_leftover_count = 3'd0;
                n_group_count    = 3'd0;
            end else begin
                n_leftover_bits  = tail[3:0];
                n_leftover_count = rem[2:0];
                n_group_count    = grp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leftover_bits  <= 4'd0;
            r_leftover_count <= 3'd0;
            r_group_count    <= 3'd0;
        end else begin
            r_leftover_bits  <= n_leftover_bits;
            r_leftover_count <= n_leftover_count;
            r_group_count    <= n_group_count;
        end
    end

endmodule

### hdl/benc_queue.sv
module benc_queue import benc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head
);

    t_job       r_mem [C_QUEUE_DEPTH];
    logic [1:0] r_count;
    logic       r_head, r_tail;

    assign o_full       = (r_count == 2'(C_QUEUE_DEPTH));
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
        end else begin
            if (i_push) r_tail <= ~r_tail;
            if (i_pop)  r_head <= ~r_head;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

### hdl/benc_back.sv
module benc_back import benc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_head_valid,
    input  t_job     i_head,
    output logic     o_pop,
    output logic     o_valid,
    input  logic     i_stall,
    output t_enc_out o_data
);

    logic [2:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    t_enc_out   r_out, n_out;
    logic       advance, last;
    logic [7:0] ch;

    assign advance = !r_valid || !i_stall;
    assign last    = ({1'b0, r_idx} == (i_head.n_total - 4'd1));
    assign o_pop   = advance && i_head_valid && last;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_comb begin
        ch = C_PAD_CHAR;
        if (r_idx < {1'b0, i_head.n_real}) begin
            case (r_idx)
                3'd0:    ch = i_head.chars[0];
                3'd1:    ch = i_head.chars[1];
                3'd2:    ch = i_head.chars[2];
                default: ch = C_PAD_CHAR;
            endcase
        end
    end

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_out   = r_out;
        if (advance) begin
            n_valid = i_head_valid;
            if (i_head_valid) begin
                n_out.out_char    = ch;
                n_out.run_last    = last;
                n_out.message_end = last && i_head.fin;
                n_idx             = last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

endmodule

### hdl/base64_base32_encoder_core.sv
// Channel   Direction  Handshake          Beat payload
// input     in         i_valid / o_stall  t_enc_in  (data_byte, final_byte)
// output    out        o_valid / i_stall  t_enc_out (out_char, run_last, message_end)
// config    in         APB psel/penable   alphabet_mode at byte address 0
//
// A byte is accepted and queued as a job of 1..8 output beats.
// The output sequencer emits one beat per cycle while i_stall is low; a byte
// yields 1 or 2 characters mid-message, up to 8 on the last one.
// The input side stalls only while the two-entry job queue is full.
// Reset is synchronous, active low; mode returns to base64 and state clears.
// Any write to alphabet_mode also abandons the message in progress.
module base64_base32_encoder_core import benc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_enc_in     i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_enc_out    o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic  r_alphabet_mode;
    logic  cfg_write;
    logic  reg_hit;
    t_ctrl ctrl;

    logic  q_push, q_pop, q_full, q_head_valid;
    t_job  job, head;

    // Word index lives in paddr[2]; the byte offset bits are ignored.
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[2] == C_REG_ALPHABET_MODE);
    assign cfg_write = psel && penable && pwrite && reg_hit;
    assign prdata    = reg_hit ? {31'd0, r_alphabet_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_mode <= 1'b0;
        end else if (cfg_write) begin
            r_alphabet_mode <= pwdata[0];
        end
    end

    assign ctrl.mode  = r_alphabet_mode;
    assign ctrl.clear = cfg_write;

    // Hold off the producer only when no queue slot is free.
    assign o_stall = q_full;

    benc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (job)
    );

    benc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_job        (job),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (head)
    );

    benc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (head),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import benc_pkg::*;

    // Allow the encoder this many cycles to settle after its last character.
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned RANDOM_ITEMS  = 420;
    localparam logic [2:0]  ADDR_MODE     = {C_REG_ALPHABET_MODE, 2'b00};
    localparam logic        MODE_BASE64   = 1'b0;
    localparam logic        MODE_BASE32   = 1'b1;

    // Predict encoded characters per accepted byte and hold them until they
    // come out of the encoder, oldest first.
    class encoder_scoreboard;
        string    b64_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        string    b32_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
        logic        mode;
        logic [3:0]  carry_bits;
        int unsigned carry_cnt;
        int unsigned char_cnt;
        t_enc_out    expected_chars[$];
        int unsigned errors;

        function new();
            mode   = MODE_BASE64;
            errors = 0;
            clear_message();
        endfunction

        function void clear_message();
            carry_bits = '0;
            carry_cnt  = 0;
            char_cnt   = 0;
        endfunction

        // Store the mode and drop any message in progress.
        function void set_mode(logic m);
            mode = m;
            clear_message();
        endfunction

        function logic [7:0] to_char(int unsigned v);
            if (mode == MODE_BASE32) begin
                return b32_set[v];
            end
            return b64_set[v];
        endfunction

        function void note_byte(t_enc_in beat);
            int unsigned width;
            int unsigned grp;
            int unsigned nbits;
            int unsigned acc;
            int unsigned mask;
            logic [7:0]  chars[$];
            t_enc_out    item;
            width = (mode == MODE_BASE32) ? 5 : 6;
            grp   = (mode == MODE_BASE32) ? 8 : 4;
            mask  = (1 << width) - 1;
            nbits = carry_cnt + 8;
            acc   = {carry_bits, beat.data_byte};
            acc   = acc & ((1 << nbits) - 1);
            while (nbits >= width) begin
                nbits = nbits - width;
                chars.push_back(to_char((acc >> nbits) & mask));
                char_cnt = (char_cnt + 1) % 8;
            end
            acc = acc & ((1 << nbits) - 1);
            if (beat.final_byte) begin
                if (nbits > 0) begin
                    chars.push_back(to_char((acc << (width - nbits)) & mask));
                    char_cnt = (char_cnt + 1) % 8;
                end
                while ((char_cnt % grp) != 0) begin
                    chars.push_back(C_PAD_CHAR);
                    char_cnt = (char_cnt + 1) % 8;
                end
                clear_message();
            end else begin
                carry_bits = acc[3:0];
                carry_cnt  = nbits;
            end
            foreach (chars[k]) begin
                item.out_char    = chars[k];
                item.run_last    = (k == chars.size() - 1);
                item.message_end = item.run_last && beat.final_byte;
                expected_chars.push_back(item);
            end
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_char(t_enc_out got);
            t_enc_out want;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected char %02h", got.out_char));
                return;
            end
            want = expected_chars.pop_front();
            if (got.out_char !== want.out_char) begin
                report($sformatf("out_char %02h, want %02h", got.out_char, want.out_char));
            end
            if (got.run_last !== want.run_last) begin
                report($sformatf("run_last %b, want %b on char %02h",
                                 got.run_last, want.run_last, want.out_char));
            end
            if (got.message_end !== want.message_end) begin
                report($sformatf("message_end %b, want %b on char %02h",
                                 got.message_end, want.message_end, want.out_char));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_enc_in     i_data;
    logic        o_valid;
    logic        i_stall;
    t_enc_out    o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    encoder_scoreboard sb;
    logic        gaps_on;     // random idling on both channels
    int unsigned bytes_sent;

    base64_base32_encoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the output side now and then; change only on the falling edge.
    always @(negedge i_clk) begin
        i_stall <= gaps_on && ($urandom_range(99) < 6);
    end

    // Sample both channels at the rising edge, before any register updates.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_byte(i_data);
            end
            if (o_valid && !i_stall) begin
                sb.check_char(o_data);
            end
        end
    end

    // Pick a message byte, biased toward the all-zero and all-one extremes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: begin
                return 8'h00;
            end
            1: begin
                return 8'hFF;
            end
            default: begin
                return 8'($urandom());
            end
        endcase
    endfunction

    // Present one beat; hold it until accepted. Enter and leave on a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (gaps_on && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, final_byte: fin};
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every predicted character has come out.
    task automatic wait_chars_out();
        i_valid <= 1'b0;
        while (sb.expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write the mode register, then read it back in a back-to-back transfer.
    // Call only with the encoder idle, on a falling edge.
    task automatic set_alphabet(input logic [31:0] value);
        logic [31:0] want;
        want    = {31'b0, value[0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MODE;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_mode(value[0]);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            sb.report($sformatf("mode readback %08h, want %08h", prdata, want));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Send a message of len bytes; an abandoned one never gets its final flag.
    task automatic send_message(input int unsigned len, input bit abandon);
        bit pause_mid;
        pause_mid = (len > 3) && ($urandom_range(7) == 0);
        for (int unsigned i = 0; i < len; i++) begin
            if (pause_mid && i == len / 2) begin
                wait_chars_out();
            end
            send_byte(pick_byte(), (i == len - 1) && !abandon);
        end
    endtask

    initial begin
        logic [31:0] cfg;
        logic        next_mode;
        int unsigned phase;
        int unsigned n_msgs;
        sb         = new();
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_stall    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        gaps_on    = 1'b1;
        bytes_sent = 0;
        phase      = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed base64 from the reset mode: one, two and three byte groups.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        // Hold the sender until all output drains, mid-message.
        send_byte(8'h80, 1'b0);
        wait_chars_out();
        send_byte(8'h01, 1'b1);
        // Abandon a message by rewriting the same mode.
        send_byte(8'h12, 1'b0);
        wait_chars_out();
        set_alphabet({31'h7FFF_FFFF, MODE_BASE64});
        send_byte(8'h34, 1'b1);

        // Directed base32: full padding, a full group, and a partial symbol.
        wait_chars_out();
        set_alphabet({31'h0, MODE_BASE32});
        send_byte(8'hFF, 1'b1);
        send_byte(8'h66, 1'b0);
        send_byte(8'h6F, 1'b0);
        send_byte(8'h6F, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        wait_chars_out();
        set_alphabet({31'h5555_5555, MODE_BASE32});
        send_byte(8'h00, 1'b1);

        // Random phases: each one starts with a mode write, flips the mode
        // most of the time, and rewrites the same mode now and then.
        bytes_sent = 0;
        while (bytes_sent < RANDOM_ITEMS) begin
            phase++;
            wait_chars_out();
            next_mode = (phase % 3 == 0) ? sb.mode : ~sb.mode;
            cfg       = $urandom();
            cfg[0]    = next_mode;
            set_alphabet(cfg);
            // Run one long phase with no idling on either side.
            gaps_on = (phase != 3);
            n_msgs  = (phase == 3) ? 12 : $urandom_range(3, 6);
            for (int unsigned m = 0; m < n_msgs; m++) begin
                send_message(($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 9),
                             (m == n_msgs - 1) && ($urandom_range(3) == 0));
            end
        end
        gaps_on = 1'b1;

        i_valid <= 1'b0;
        while (sb.expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Bound the run well beyond the slowest legal completion.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
